### rtl/core/assert_macros.svh
// assertion helpers used by the checker file dtfp_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define DTFP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define DTFP_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/dtfp_pkg.sv
package dtfp_pkg;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 61;
    localparam int DATA_W  = 64;
    localparam int INT_W   = 60;

    // ascii codes the parser looks for
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // largest integer-part magnitude in result units, and integer limit before a digit append
    localparam logic [63:0]      UNITS_CEILING = 64'd900000000000000000;
    localparam logic [INT_W-1:0] INT_OVF_LIMIT = 60'd90000000000000000;

    // widest legal result magnitude over the whole fraction digit range
    localparam logic signed [VALUE_W-1:0] SCALED_LIMIT = 61'sd900000000099999999;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_MALFORMED = 2'd1,
        ERR_DECIMALS  = 2'd2,
        ERR_RANGE     = 2'd3
    } dtfp_err_t;

    typedef enum logic [2:0] {
        PH_START = 3'b001,
        PH_INT   = 3'b010,
        PH_FRAC  = 3'b100
    } dtfp_phase_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        dtfp_err_t          err;
    } dtfp_result_t;

    // power of ten, only evaluated at elaboration
    function automatic logic [63:0] pow10(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int k = 0; k < n; k++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

endpackage

### rtl/core/decimal_text_to_fixed_point.sv
// Decimal text to fixed point. Feed one ASCII character per item on the s_ side
// (optional sign, integer digits, optional '.' and up to FRACTION_DIGITS fraction
// digits) with s_tlast on the final character; that character produces one item on
// the m_ side holding the signed value in units of 10^-FRACTION_DIGITS in m_tdata
// and the error code in m_tuser (0 ok, 1 malformed, 2 too many decimals, 3 out of
// range; the value is zero on any error). One character is taken every cycle while
// the m_ side keeps up. The last character of a number is held in the input register
// while the single-pass accumulator update (a multiply-by-ten adder on the running
// total for integer digits, a weighted add for fraction digits) forms the value
// loaded into the result register, which presents it on the m_ side. A result held by
// a low m_tready stalls the input once the input register is also full. Other
// characters give no output item.
module decimal_text_to_fixed_point #(
    parameter int FRACTION_DIGITS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [60:0] scaled_value, [63:61] zero
    output logic [1:0]  m_tuser    // [1:0] error_code
);
    import dtfp_pkg::*;

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    dtfp_result_t      out_res_reg;
    dtfp_result_t      result;
    logic              advance;
    logic              step;

    // output register frees up when empty or taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    dtfp_parse_core #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .char_code (in_char_reg),
        .last_char (in_last_reg),
        .result    (result)
    );

    // result register, loaded on the last character of a number
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step && in_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && in_last_reg) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(DATA_W-VALUE_W){1'b0}}, out_res_reg.value};
    assign m_tuser  = out_res_reg.err;

endmodule

### rtl/core/dtfp_parse_core.sv
module dtfp_parse_core #(
    parameter int FRACTION_DIGITS = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [7:0]                  char_code,
    input  logic                        last_char,
    output dtfp_pkg::dtfp_result_t      result
);
    import dtfp_pkg::*;

    localparam logic [63:0] SCALE = pow10(FRACTION_DIGITS);
    localparam logic [INT_W-1:0] INT_BIG_EDGE = INT_W'(UNITS_CEILING / SCALE / 10);
    localparam int W_W   = $clog2(SCALE + 64'd1);
    localparam int CNT_W = $clog2(FRACTION_DIGITS + 1);
    localparam int IDX_W = (FRACTION_DIGITS > 1) ? $clog2(FRACTION_DIGITS) : 1;
    localparam int LUT_N = 1 << IDX_W;

    dtfp_phase_t        phase_reg, phase_next;
    logic               neg_reg, neg_next;
    logic [INT_W-1:0]   int_reg, int_next;
    logic               saw_reg, saw_next;
    logic               big_reg, big_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    dtfp_err_t          err_reg, err_next;
    logic [VALUE_W-1:0] total_reg, total_next;

    logic [W_W-1:0]     frac_weight [LUT_N];
    logic [W_W-1:0]     weight;
    logic [W_W+3:0]     product;
    logic [VALUE_W-1:0] addend;
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] total_upd;
    logic [3:0]         digit;
    logic               is_digit;
    logic               in_int;
    logic               big_hit;
    dtfp_err_t          err_end;

    // weight of each fraction position, in result units
    for (genvar k = 0; k < LUT_N; k++) begin : g_weight
        assign frac_weight[k] = (k < FRACTION_DIGITS) ?
                                W_W'(pow10(FRACTION_DIGITS - 1 - k)) : '0;
    end

    assign digit    = char_code[3:0];
    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign in_int   = (phase_reg == PH_START) || (phase_reg == PH_INT);

    // signed running total: int part times scale, plus weighted fraction digits
    assign weight    = in_int ? W_W'(SCALE) : frac_weight[count_reg[IDX_W-1:0]];
    assign product   = (W_W+4)'(digit) * (W_W+4)'(weight);
    assign addend    = {{(VALUE_W-W_W-4){1'b0}}, product};
    assign base      = in_int ? ((total_reg << 3) + (total_reg << 1)) : total_reg;
    assign total_upd = neg_next ? (base - addend) : (base + addend);

    // integer part would pass the range limit after this digit
    assign big_hit = (int_reg > INT_BIG_EDGE) ||
                     ((int_reg == INT_BIG_EDGE) && (digit != 4'd0));

    // per-character state update
    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        int_next   = int_reg;
        saw_next   = saw_reg;
        big_next   = big_reg;
        count_next = count_reg;
        err_next   = err_reg;
        total_next = total_reg;

        if (phase_reg == PH_START) begin
            phase_next = PH_INT;
        end

        if ((phase_reg == PH_START) && ((char_code == CH_PLUS) || (char_code == CH_MINUS))) begin
            neg_next = (char_code == CH_MINUS);
        end else if (in_int) begin
            if (char_code == CH_DOT) begin
                if (!saw_reg && (err_reg == ERR_NONE)) begin
                    err_next = ERR_MALFORMED;
                end
                phase_next = PH_FRAC;
            end else if (!is_digit) begin
                if (err_reg == ERR_NONE) begin
                    err_next = ERR_MALFORMED;
                end
            end else if (int_reg > INT_OVF_LIMIT) begin
                if (err_reg == ERR_NONE) begin
                    err_next = ERR_RANGE;
                end
            end else if (err_reg == ERR_NONE) begin
                int_next = (int_reg << 3) + (int_reg << 1) + INT_W'(digit);
                saw_next = 1'b1;
                big_next = big_reg | big_hit;
                if (!big_next) begin
                    total_next = total_upd;
                end
            end
        end else begin
            if (!is_digit) begin
                if (err_reg == ERR_NONE) begin
                    err_next = ERR_MALFORMED;
                end
            end else if (count_reg >= CNT_W'(FRACTION_DIGITS)) begin
                if (err_reg == ERR_NONE) begin
                    err_next = ERR_DECIMALS;
                end
            end else if (err_reg == ERR_NONE) begin
                count_next = count_reg + CNT_W'(1);
                total_next = total_upd;
            end
        end
    end

    // end-of-number checks and the result
    always_comb begin
        err_end = err_next;
        if ((phase_next != PH_FRAC) && !saw_next && (err_end == ERR_NONE)) begin
            err_end = ERR_MALFORMED;
        end
        if ((err_end == ERR_NONE) && big_next) begin
            err_end = ERR_RANGE;
        end
        result.err   = err_end;
        result.value = (err_end == ERR_NONE) ? total_next : '0;
    end

    // state registers, cleared at the end of each number
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_char)) begin
            phase_reg <= PH_START;
            neg_reg   <= 1'b0;
            int_reg   <= '0;
            saw_reg   <= 1'b0;
            big_reg   <= 1'b0;
            count_reg <= '0;
            err_reg   <= ERR_NONE;
            total_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            int_reg   <= int_next;
            saw_reg   <= saw_next;
            big_reg   <= big_next;
            count_reg <= count_next;
            err_reg   <= err_next;
            total_reg <= total_next;
        end
    end

endmodule

### rtl/core/dtfp_checker.sv
`include "assert_macros.svh"

module dtfp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import dtfp_pkg::*;

    // a stalled result item holds
    `DTFP_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result item changed while stalled")

    // an error result carries a zero value
    `DTFP_ASSERT_IMP(a_err_zero, aclk, aresetn, m_tvalid && (m_tuser != ERR_NONE), m_tdata == 64'd0, "error result with nonzero value")

    // a good result stays inside the legal range
    `DTFP_ASSERT_IMP(a_ok_range, aclk, aresetn, m_tvalid && (m_tuser == ERR_NONE), ($signed(m_tdata[60:0]) <= SCALED_LIMIT) && ($signed(m_tdata[60:0]) >= -SCALED_LIMIT) && (m_tdata[63:61] == 3'd0), "good result out of range")

    // input only backs up when the result side is stalled
    `DTFP_ASSERT_IMP(a_bp_cause, aclk, aresetn, !s_tready, m_tvalid && !m_tready, "input stalled without output backpressure")

endmodule

bind decimal_text_to_fixed_point dtfp_checker u_dtfp_checker (.*);

### tb/sv/tb_top.sv
module tb_top;
    import dtfp_pkg::*;

    localparam int          FRAC_DIGITS  = 4;
    localparam logic [63:0] UNIT_SCALE   = 64'd10000;
    localparam logic [63:0] DIGIT_LIMIT  = UNITS_CEILING / 64'd10;
    localparam logic [63:0] END_LIMIT    = UNITS_CEILING / UNIT_SCALE;
    localparam int          STALL_LIMIT  = 5000;
    localparam int          LONG_HOLD    = 300;
    localparam int          DRAIN_CYCLES = 8;
    localparam string       NUMBER_CHARS = "+-.0123456789";

    // tracks one number being parsed and holds the values it must produce
    class parsed_number_checker;
        dtfp_phase_t  phase;
        bit           negative;
        logic [59:0]  int_acc;
        bit           saw_digit;
        logic [13:0]  frac_acc;
        logic [2:0]   frac_cnt;
        dtfp_err_t    first_err;
        dtfp_result_t expected_values[$];
        int           mismatches;

        function new();
            mismatches = 0;
            clear_number();
        endfunction

        function void clear_number();
            phase     = PH_START;
            negative  = 1'b0;
            int_acc   = '0;
            saw_digit = 1'b0;
            frac_acc  = '0;
            frac_cnt  = '0;
            first_err = ERR_NONE;
        endfunction

        function void raise(dtfp_err_t code);
            if (first_err == ERR_NONE)
                first_err = code;
        endfunction

        // advance the parse on one accepted character, queue a value on the last one
        function void note_char(logic [7:0] c, bit last);
            dtfp_result_t res;
            logic [63:0]  frac;
            logic [63:0]  total;
            bit           is_digit;
            bit           sign_taken;
            is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
            sign_taken = 1'b0;
            if (phase == PH_START) begin
                phase = PH_INT;
                if (c == CH_PLUS || c == CH_MINUS) begin
                    negative   = (c == CH_MINUS);
                    sign_taken = 1'b1;
                end
            end
            if (!sign_taken) begin
                if (phase == PH_INT) begin
                    if (c == CH_DOT) begin
                        if (!saw_digit)
                            raise(ERR_MALFORMED);
                        phase = PH_FRAC;
                    end else if (!is_digit) begin
                        raise(ERR_MALFORMED);
                    end else if ({4'b0, int_acc} > DIGIT_LIMIT) begin
                        raise(ERR_RANGE);
                    end else if (first_err == ERR_NONE) begin
                        int_acc   = int_acc * 60'd10 + (c - CH_ZERO);
                        saw_digit = 1'b1;
                    end
                end else begin
                    if (!is_digit) begin
                        raise(ERR_MALFORMED);
                    end else if (frac_cnt >= FRAC_DIGITS) begin
                        raise(ERR_DECIMALS);
                    end else if (first_err == ERR_NONE) begin
                        frac_acc = frac_acc * 14'd10 + (c - CH_ZERO);
                        frac_cnt = frac_cnt + 3'd1;
                    end
                end
            end
            if (!last)
                return;

            // end of number: late checks, then scale and apply the sign
            if (phase != PH_FRAC && !saw_digit)
                raise(ERR_MALFORMED);
            if (first_err == ERR_NONE && {4'b0, int_acc} > END_LIMIT)
                raise(ERR_RANGE);
            total = '0;
            if (first_err == ERR_NONE) begin
                frac = {50'b0, frac_acc};
                for (int k = frac_cnt; k < FRAC_DIGITS; k++)
                    frac = frac * 64'd10;
                total = {4'b0, int_acc} * UNIT_SCALE + frac;
                if (negative)
                    total = ~total + 64'd1;
            end
            res.value = total[VALUE_W-1:0];
            res.err   = first_err;
            expected_values.insert(expected_values.size(), res);
            clear_number();
        endfunction

        // compare one accepted result item with the oldest expected value
        function void check_value(logic [63:0] data, logic [1:0] user);
            dtfp_result_t exp_res;
            if (expected_values.size() == 0) begin
                $display("%0t: unexpected result value=%0d err=%0d", $time,
                         $signed(data[VALUE_W-1:0]), user);
                mismatches++;
                return;
            end
            exp_res = expected_values.pop_front();
            if (data[VALUE_W-1:0] !== exp_res.value) begin
                $display("%0t: scaled value mismatch expected %0d actual %0d", $time,
                         $signed(exp_res.value), $signed(data[VALUE_W-1:0]));
                mismatches++;
            end
            if (user !== exp_res.err) begin
                $display("%0t: error code mismatch expected %0d actual %0d", $time,
                         exp_res.err, user);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;

    parsed_number_checker checker_sb;
    logic [7:0]  text[$];
    int          chars_sent   = 0;
    int          burst_left   = 0;
    int          idle_cycles  = 0;
    bit          hold_request = 1'b0;

    decimal_text_to_fixed_point #(
        .FRACTION_DIGITS(FRAC_DIGITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #10 aclk = ~aclk;

    // handshakes seen at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                checker_sb.note_char(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                checker_sb.check_value(m_tdata, m_tuser);
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("** decimal_text_to_fixed_point: FAILED **");
                    $finish;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int mode;
        int seg_left;
        int hold_left;
        int phase_cnt;
        mode      = 0;
        seg_left  = 0;
        hold_left = 0;
        phase_cnt = 0;
        forever begin
            @(negedge aclk);
            phase_cnt++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(20, 120);
                end
                seg_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (phase_cnt % 3 == 0);
                endcase
            end
        end
    end

    // offer one character, in bursts with random gaps between them
    task automatic send_item(input logic [7:0] c, input bit last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        chars_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text();
        foreach (text[i])
            send_item(text[i], i == text.size() - 1);
    endtask

    task automatic load_string(input string s);
        text.delete();
        for (int i = 0; i < s.len(); i++)
            text.insert(text.size(), s[i]);
    endtask

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // optional sign, integer digits of varied length, optional fraction
    task automatic build_well_formed();
        int sel;
        int n;
        bit zeros;
        text.delete();
        case ($urandom_range(0, 3))
            0: text.insert(text.size(), CH_MINUS);
            1: text.insert(text.size(), CH_PLUS);
            default: ;
        endcase
        sel = $urandom_range(0, 19);
        if (sel == 17) begin
            // right at the integer range limit or just past it
            zeros = 1'($urandom_range(0, 1));
            text.insert(text.size(), CH_NINE);
            repeat (13) text.insert(text.size(), zeros ? CH_ZERO : rand_digit());
        end else begin
            if (sel < 14)
                n = $urandom_range(1, 4);
            else if (sel < 17)
                n = $urandom_range(5, 13);
            else if (sel == 18)
                n = $urandom_range(15, 18);
            else
                n = $urandom_range(19, 22);
            repeat (n) text.insert(text.size(), rand_digit());
        end
        if ($urandom_range(0, 2) != 0) begin
            text.insert(text.size(), CH_DOT);
            if ($urandom_range(0, 9) < 8)
                n = $urandom_range(0, FRAC_DIGITS);
            else
                n = $urandom_range(FRAC_DIGITS + 1, FRAC_DIGITS + 2);
            repeat (n) text.insert(text.size(), rand_digit());
        end
    endtask

    // break a good number: overwrite a character or slip in a sign or dot
    task automatic corrupt_text();
        int pos;
        pos = $urandom_range(0, text.size() - 1);
        if ($urandom_range(0, 1) == 0)
            text[pos] = 8'($urandom_range(0, 255));
        else
            text.insert(pos, NUMBER_CHARS[$urandom_range(0, 2)]);
    endtask

    task automatic build_noise();
        int n;
        text.delete();
        n = $urandom_range(1, 5);
        repeat (n) begin
            if ($urandom_range(0, 1) == 0)
                text.insert(text.size(), 8'($urandom_range(0, 255)));
            else
                text.insert(text.size(), NUMBER_CHARS[$urandom_range(0, 12)]);
        end
    endtask

    task automatic send_random_number();
        int kind;
        kind = $urandom_range(0, 19);
        if (kind < 13) begin
            build_well_formed();
        end else if (kind < 17) begin
            build_well_formed();
            corrupt_text();
        end else begin
            build_noise();
        end
        send_text();
    endtask

    // main sequence
    initial begin
        string directed_texts[$];
        checker_sb = new();
        directed_texts = '{"-0", "+9.1", "-", ".5", "1.23456", "5+", "1..", "7."};
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed numbers, then the lowest and highest character codes alone
        foreach (directed_texts[i]) begin
            load_string(directed_texts[i]);
            send_text();
        end
        text = '{8'h00};
        send_text();
        text = '{8'hFF};
        send_text();

        // sender pauses until every value has come back
        s_tvalid <= 1'b0;
        while (checker_sb.expected_values.size() != 0) @(negedge aclk);
        @(negedge aclk);
        burst_left = 0;

        while (chars_sent < 450)
            send_random_number();
        // receiver holds off while characters keep coming
        hold_request = 1'b1;
        while (chars_sent < 850)
            send_random_number();

        s_tvalid <= 1'b0;
        while (checker_sb.expected_values.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (checker_sb.mismatches == 0 && checker_sb.expected_values.size() == 0)
            $display("** decimal_text_to_fixed_point: PASSED **");
        else
            $display("** decimal_text_to_fixed_point: FAILED **");
        $finish;
    end

endmodule
